@@ hw/rtl/stq_pkg.sv @@
// Shared types and constants for the sorted timer queue.
// No dependencies; used by stq_cell and sorted_timer_queue_unit.
package stq_pkg;

   localparam int unsigned MAX_ENTRIES_DEF = 16;
   localparam int unsigned ID_W    = 32;
   localparam int unsigned TIME_W  = 40;
   localparam int unsigned TITLE_W = 16;
   localparam int unsigned KIND_W  = 4;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned HELD_W  = 5;
   localparam logic [TIME_W-1:0] FLOOR_RESET = 40'd1700000000;

   typedef enum logic [1:0] {
      CMD_SCHED  = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_POP    = 2'd2,
      CMD_BAD    = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE     = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_NOTDUE   = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  time_v;
      logic [TITLE_W-1:0] title;
      logic [KIND_W-1:0]  kind;
   } slot_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              go;
      logic              rm_id_en;
      logic              insert_en;
      logic [ID_W-1:0]   key_id;
      logic [TIME_W-1:0] key_time;
      slot_type          new_slot;
   } ctrl_type;

endpackage

@@ hw/rtl/sorted_timer_queue_unit.sv @@
// Top level of the sorted timer queue: command register, controller, cell chain.
// Depends on stq_pkg and stq_cell.
//
// Usage:
//  - req_ channel carries one command (schedule, cancel, pop) per transfer.
//  - rsp_ channel returns exactly one result per command: status, popped
//    entry fields (zero unless a pop succeeded) and the entry count after it.
//  - csr_ port writes min_valid_time; pops below it report nothing due.
// Timing:
//  - A command is latched in the transfer cycle and executed in the next,
//    when every cell of the chain takes its new content at once.
//  - Result is registered at the end of the execute state; no new command
//    is taken while one executes, and the next request transfer may share
//    its edge with the result transfer. The chain update and the single
//    output register set the pace.
//  - While a result waits under rsp_stall, req_stall stays high.
// Reset:
//  - Synchronous, active high. Table empties (cell valid bits cleared),
//    fill count zero, floor back to 1700000000, no result pending.
module sorted_timer_queue_unit #(
   parameter int unsigned MAX_ENTRIES = stq_pkg::MAX_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic signed [31:0]           req_entry_id,
   input  logic [39:0]                  req_trigger_time,
   input  logic [15:0]                  req_title_ref,
   input  logic [3:0]                   req_kind_code,
   input  logic [39:0]                  req_now_time,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic signed [31:0]           rsp_out_id,
   output logic [39:0]                  rsp_out_time,
   output logic [15:0]                  rsp_out_title_ref,
   output logic [3:0]                   rsp_out_kind,
   output logic [4:0]                   rsp_entries_held,
   input  logic                         csr_wr_en,
   input  logic [39:0]                  csr_wr_data
);

   localparam int unsigned FILL_W = $clog2(MAX_ENTRIES + 1);

   // command register
   stq_pkg::cmd_type   cmd_ff;
   logic [31:0]        id_ff;
   logic [39:0]        time_ff, now_ff;
   logic [15:0]        title_ff;
   logic [3:0]         kind_ff;

   stq_pkg::state_type state_ff, state_in;
   logic [39:0]        floor_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         status_ff;
   logic [31:0]        oid_ff;
   logic [39:0]        otime_ff;
   logic [15:0]        otitle_ff;
   logic [3:0]         okind_ff;
   logic [4:0]         held_ff;

   stq_pkg::ctrl_type  ctrl;
   stq_pkg::slot_type  slots [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match_v, le_v, gone_v, valid_v;

   logic               go, sched_ok, found, full, pop_go, removed;
   stq_pkg::status_type status_c;
   logic [FILL_W+4:0]  held_wide;

   // a result leaving at this edge frees the input at the same edge
   assign req_stall = (state_ff != stq_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign go        = (state_ff == stq_pkg::S_EXEC);
   assign found     = |match_v;
   assign full      = (fill_ff == FILL_W'(MAX_ENTRIES));
   assign sched_ok  = (cmd_ff == stq_pkg::CMD_SCHED) && (id_ff != '0) &&
                      (time_ff != '0) && (title_ff != '0);
   // head is checked against the pop time, not the schedule time
   assign pop_go    = (cmd_ff == stq_pkg::CMD_POP) && slots[0].valid &&
                      (now_ff >= floor_ff) && (slots[0].time_v <= now_ff);
   assign removed   = ((sched_ok || cmd_ff == stq_pkg::CMD_CANCEL) && found) || pop_go;

   always_comb begin
      ctrl.go             = go;
      ctrl.rm_id_en       = sched_ok || (cmd_ff == stq_pkg::CMD_CANCEL);
      ctrl.insert_en      = sched_ok && (found || !full);
      ctrl.key_id         = id_ff;
      ctrl.key_time       = time_ff;
      ctrl.new_slot.valid = 1'b1;
      ctrl.new_slot.id    = id_ff;
      ctrl.new_slot.time_v = time_ff;
      ctrl.new_slot.title = title_ff;
      ctrl.new_slot.kind  = kind_ff;
   end

   // cell chain
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      stq_pkg::slot_type lslot, rslot;
      logic              lle, lgone, rle;
      if (i == 0) begin : g_first
         assign lslot = '0;
         assign lle   = 1'b1;   // nothing stands before the head
         assign lgone = 1'b0;
      end else begin : g_mid
         assign lslot = slots[i-1];
         assign lle   = le_v[i-1];
         assign lgone = gone_v[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign rslot = '0;
         assign rle   = 1'b0;
      end else begin : g_body
         assign rslot = slots[i+1];
         assign rle   = le_v[i+1];
      end
      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .force_rm   ((i == 0) && pop_go),
         .left_slot  (lslot),
         .left_le    (lle),
         .left_gone  (lgone),
         .right_slot (rslot),
         .right_le   (rle),
         .slot       (slots[i]),
         .match      (match_v[i]),
         .le         (le_v[i]),
         .gone       (gone_v[i])
      );
      assign valid_v[i] = slots[i].valid;
   end

   always_comb begin
      case (cmd_ff)
         stq_pkg::CMD_SCHED: begin
            if (!sched_ok)          status_c = stq_pkg::ST_INVALID;
            else if (found || !full) status_c = stq_pkg::ST_DONE;
            else                    status_c = stq_pkg::ST_FULL;
         end
         stq_pkg::CMD_CANCEL: status_c = found ? stq_pkg::ST_DONE : stq_pkg::ST_NOTFOUND;
         stq_pkg::CMD_POP:    status_c = pop_go ? stq_pkg::ST_DONE : stq_pkg::ST_NOTDUE;
         default:             status_c = stq_pkg::ST_INVALID;
      endcase
      fill_in = fill_ff - FILL_W'(removed) + FILL_W'(ctrl.insert_en);
      held_wide = {5'b0, fill_in};
   end

   // controller
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         stq_pkg::S_IDLE: if (req_valid && !req_stall) state_in = stq_pkg::S_EXEC;
         stq_pkg::S_EXEC: begin
            state_in     = stq_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = stq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         floor_ff     <= stq_pkg::FLOOR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) fill_ff <= fill_in;
         if (csr_wr_en) floor_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff   <= stq_pkg::cmd_type'(req_cmd);
         id_ff    <= req_entry_id;
         time_ff  <= req_trigger_time;
         title_ff <= req_title_ref;
         kind_ff  <= req_kind_code;
         now_ff   <= req_now_time;
      end
      if (go) begin
         status_ff <= status_c;
         oid_ff    <= pop_go ? slots[0].id     : '0;
         otime_ff  <= pop_go ? slots[0].time_v : '0;
         otitle_ff <= pop_go ? slots[0].title  : '0;
         okind_ff  <= pop_go ? slots[0].kind   : '0;
         held_ff   <= held_wide[4:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_id        = oid_ff;
   assign rsp_out_time      = otime_ff;
   assign rsp_out_title_ref = otitle_ff;
   assign rsp_out_kind      = okind_ff;
   assign rsp_entries_held  = held_ff;

   // occupied cells always match the fill count
   a_fill_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_v) == int'(fill_ff))
      else $error("cell valid bits disagree with fill count");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_ENTRIES))
      else $error("fill count above capacity");

   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff && state_ff == stq_pkg::S_IDLE)
      else $error("executed command gave no result");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> go)
      else $error("accepted command not executed");

endmodule

@@ hw/rtl/stq_cell.sv @@
// One slot of the sorted chain: holds an entry, closes gaps and opens room.
// Depends on stq_pkg.
module stq_cell (
   input  logic              clock,
   input  logic              reset,
   input  stq_pkg::ctrl_type ctrl,
   input  logic              force_rm,
   input  stq_pkg::slot_type left_slot,
   input  logic              left_le,
   input  logic              left_gone,
   input  stq_pkg::slot_type right_slot,
   input  logic              right_le,
   output stq_pkg::slot_type slot,
   output logic              match,
   output logic              le,
   output logic              gone
);

   stq_pkg::slot_type slot_ff, slot_in;
   stq_pkg::slot_type r_own, r_left;
   logic              rle_own, rle_left;

   assign slot  = slot_ff;
   assign match = slot_ff.valid && (slot_ff.id == ctrl.key_id);
   assign le    = slot_ff.valid && (slot_ff.time_v <= ctrl.key_time);
   assign gone  = left_gone | (match & ctrl.rm_id_en) | force_rm;

   always_comb begin
      // content after removal, at this place and at the left neighbor
      r_own    = gone ? right_slot : slot_ff;
      rle_own  = gone ? right_le : le;
      r_left   = left_gone ? slot_ff : left_slot;
      rle_left = left_gone ? le : left_le;
      if (!ctrl.insert_en || rle_own) begin
         slot_in = r_own;
      end else if (rle_left) begin
         slot_in = ctrl.new_slot;
      end else begin
         slot_in = r_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (ctrl.go) begin
         slot_ff.valid <= slot_in.valid;
      end
      if (ctrl.go) begin
         slot_ff.id     <= slot_in.id;
         slot_ff.time_v <= slot_in.time_v;
         slot_ff.title  <= slot_in.title;
         slot_ff.kind   <= slot_in.kind;
      end
   end

endmodule
